// ===== rtl/core/ckh_pkg.sv =====
// shared constants, types and base coding for the canonical k-mer hasher
package ckh_pkg;

  localparam int KMER_LENGTH = 28;
  localparam int LANES       = 8;

  localparam int BASE_W      = 8;
  localparam int COUNT_W     = 4;
  localparam int HASH_W      = 56;
  localparam int MIX_W       = 64;
  localparam int WIN_W       = 2 * KMER_LENGTH;
  localparam int HIST_W      = 2 * (KMER_LENGTH - 1);
  localparam int SEQ_W       = HIST_W + 2 * LANES;
  localparam int SEEN_W      = $clog2(KMER_LENGTH);
  localparam int SUM_W       = $clog2(KMER_LENGTH + LANES);
  localparam int LANE_IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SHAMT_W     = $clog2(2 * LANES + 1);
  localparam int HASH_DEPTH  = 5;
  localparam int IN_DATA_W   = ((LANES * BASE_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((LANES * HASH_W + COUNT_W + 7) / 8) * 8;

  localparam logic [MIX_W-1:0] WIN_MASK =
    (WIN_W >= MIX_W) ? {MIX_W{1'b1}} : ((MIX_W'(1) << WIN_W) - MIX_W'(1));

  localparam logic [BASE_W-1:0] ASCII_C = 8'h43;
  localparam logic [BASE_W-1:0] ASCII_G = 8'h47;
  localparam logic [BASE_W-1:0] ASCII_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef logic [WIN_W-1:0]  win_t;
  typedef logic [HASH_W-1:0] hash_t;

  // per-request control that travels beside the lane pipelines
  typedef struct packed {
    logic                  valid;
    logic [LANE_IDX_W-1:0] first;
    logic [COUNT_W-1:0]    count;
    logic                  eos;
  } ckh_ctrl_t;

  function automatic logic [1:0] base_code(input logic [BASE_W-1:0] ch);
    logic [1:0] code;
    case (ch)
      ASCII_C: code = CODE_C;
      ASCII_G: code = CODE_G;
      ASCII_T: code = CODE_T;
      default: code = CODE_A;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/ckh_front.sv =====
// input stage: base coding, window formation per lane and sequence history
module ckh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ckh_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          s_tlast,
  output ckh_pkg::win_t                 win [ckh_pkg::LANES],
  output ckh_pkg::ckh_ctrl_t            ctrl
);

  logic                           accept;
  logic [ckh_pkg::COUNT_W-1:0]    raw_cnt;
  logic [ckh_pkg::COUNT_W-1:0]    n;
  logic [ckh_pkg::SEQ_W-1:0]      seq;
  logic [ckh_pkg::SEQ_W-1:0]      shifted;
  logic [ckh_pkg::SHAMT_W-1:0]    shamt;
  logic [ckh_pkg::HIST_W-1:0]     hist;
  logic [ckh_pkg::HIST_W-1:0]     hist_next;
  logic [ckh_pkg::SEEN_W-1:0]     seen;
  logic [ckh_pkg::SEEN_W-1:0]     seen_next;
  logic [ckh_pkg::SUM_W-1:0]      seen_sum;
  logic [ckh_pkg::SEEN_W-1:0]     gap;
  logic [ckh_pkg::COUNT_W-1:0]    hash_cnt;
  ckh_pkg::win_t                  win_d [ckh_pkg::LANES];

  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  always_comb begin
    raw_cnt = s_tdata[ckh_pkg::LANES*ckh_pkg::BASE_W +: ckh_pkg::COUNT_W];
    if (raw_cnt > ckh_pkg::COUNT_W'(ckh_pkg::LANES)) begin
      n = ckh_pkg::COUNT_W'(ckh_pkg::LANES);
    end else begin
      n = raw_cnt;
    end

    // oldest history on top, base_0 just below it, last lane lowest
    seq[ckh_pkg::SEQ_W-1 -: ckh_pkg::HIST_W] = hist;
    for (int i = 0; i < ckh_pkg::LANES; i++) begin
      seq[2*(ckh_pkg::LANES-1-i) +: 2] =
        ckh_pkg::base_code(s_tdata[i*ckh_pkg::BASE_W +: ckh_pkg::BASE_W]);
    end
    for (int i = 0; i < ckh_pkg::LANES; i++) begin
      win_d[i] = seq[2*(ckh_pkg::LANES-1-i) +: ckh_pkg::WIN_W];
    end

    shamt     = ckh_pkg::SHAMT_W'(2 * ckh_pkg::LANES) - ckh_pkg::SHAMT_W'({n, 1'b0});
    shifted   = seq >> shamt;
    hist_next = shifted[ckh_pkg::HIST_W-1:0];

    seen_sum = ckh_pkg::SUM_W'(seen) + ckh_pkg::SUM_W'(n);
    if (seen_sum >= ckh_pkg::SUM_W'(ckh_pkg::KMER_LENGTH - 1)) begin
      seen_next = ckh_pkg::SEEN_W'(ckh_pkg::KMER_LENGTH - 1);
    end else begin
      seen_next = seen_sum[ckh_pkg::SEEN_W-1:0];
    end

    // lanes before gap still fill the window, the rest produce hashes
    gap = ckh_pkg::SEEN_W'(ckh_pkg::KMER_LENGTH - 1) - seen;
    if (ckh_pkg::SUM_W'(n) > ckh_pkg::SUM_W'(gap)) begin
      hash_cnt = n - ckh_pkg::COUNT_W'(gap);
    end else begin
      hash_cnt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
      seen <= '0;
      ctrl <= '0;
    end else begin
      if (accept) begin
        hist <= s_tlast ? '0 : hist_next;
        seen <= s_tlast ? '0 : seen_next;
      end
      if (adv) begin
        ctrl.valid <= accept;
        ctrl.first <= ckh_pkg::LANE_IDX_W'(gap);
        ctrl.count <= hash_cnt;
        ctrl.eos   <= s_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win <= win_d;
    end
  end

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= ckh_pkg::SEEN_W'(ckh_pkg::KMER_LENGTH - 1))
    else $error("bases seen above window length");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> seen == '0 && hist == '0)
    else $error("history not cleared after end of sequence");

  a_count_fits: assert property (@(posedge clk) disable iff (rst)
    ctrl.valid |-> ctrl.count <= ckh_pkg::COUNT_W'(ckh_pkg::LANES))
    else $error("hash count above lane count");

endmodule

// ===== rtl/core/ckh_lane.sv =====
// one lane: canonical choice and the shift-add-xor hash over five stages
module ckh_lane (
  input  logic          clk,
  input  logic          adv,
  input  ckh_pkg::win_t win,
  output ckh_pkg::hash_t hash
);

  ckh_pkg::win_t              rc;
  logic [ckh_pkg::MIX_W-1:0]  canon;
  logic [ckh_pkg::MIX_W-1:0]  h1;
  logic [ckh_pkg::MIX_W-1:0]  h2;
  logic [ckh_pkg::MIX_W-1:0]  h3;
  logic [ckh_pkg::MIX_W-1:0]  h4;
  logic [ckh_pkg::MIX_W-1:0]  a1;
  logic [ckh_pkg::MIX_W-1:0]  a2;
  logic [ckh_pkg::MIX_W-1:0]  a3;
  logic [ckh_pkg::MIX_W-1:0]  a4;

  always_comb begin
    for (int b = 0; b < ckh_pkg::KMER_LENGTH; b++) begin
      rc[2*(ckh_pkg::KMER_LENGTH-1-b) +: 2] = ~win[2*b +: 2];
    end
    a1 = ~canon + (canon << 21);
    a2 = h1 + (h1 << 3) + (h1 << 8);
    a3 = h2 + (h2 << 2) + (h2 << 4);
    a4 = h3 + (h3 << 31);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      canon <= ckh_pkg::MIX_W'((win < rc) ? win : rc);
      h1    <= a1 ^ (a1 >> 24);
      h2    <= a2 ^ (a2 >> 14);
      h3    <= a3 ^ (a3 >> 28);
      h4    <= a4 & ckh_pkg::WIN_MASK;
    end
  end

  assign hash = h4[ckh_pkg::HASH_W-1:0];

endmodule

// ===== rtl/core/ckh_merge.sv =====
// packs the lane hashes that count, in order, into the output register
module ckh_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  ckh_pkg::ckh_ctrl_t             ctrl,
  input  ckh_pkg::hash_t                 hashes [ckh_pkg::LANES],
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ckh_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast
);

  logic [ckh_pkg::OUT_DATA_W-1:0] packed_d;
  logic [ckh_pkg::LANE_IDX_W:0]   idx;

  always_comb begin
    packed_d = '0;
    idx      = '0;
    for (int j = 0; j < ckh_pkg::LANES; j++) begin
      idx = {1'b0, ctrl.first} + (ckh_pkg::LANE_IDX_W+1)'(j);
      if (ckh_pkg::COUNT_W'(j) < ctrl.count &&
          idx < (ckh_pkg::LANE_IDX_W+1)'(ckh_pkg::LANES)) begin
        packed_d[j*ckh_pkg::HASH_W +: ckh_pkg::HASH_W] =
          hashes[idx[ckh_pkg::LANE_IDX_W-1:0]];
      end
    end
    packed_d[ckh_pkg::LANES*ckh_pkg::HASH_W +: ckh_pkg::COUNT_W] = ctrl.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= packed_d;
      m_tlast <= ctrl.eos;
    end
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[ckh_pkg::LANES*ckh_pkg::HASH_W +: ckh_pkg::COUNT_W] == '0
      |-> m_tdata[ckh_pkg::LANES*ckh_pkg::HASH_W-1:0] == '0)
    else $error("hash fields set in a request with no hashes");

  a_load_follows: assert property (@(posedge clk) disable iff (rst)
    adv && ctrl.valid |=> m_tvalid)
    else $error("request lost at the output register");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("waiting result changed before it was taken");

endmodule

// ===== rtl/core/canonical_kmer_hasher.sv =====
// top level of the canonical k-mer hasher
//
// each request carries up to eight ascii bases (base_0 oldest); they are coded
// a/c/g/t = 0/1/2/3 with any other byte read as a, appended to the last 27
// bases of the current sequence, and every base that completes a 28-base
// window yields one hash: the smaller of the window and its reverse
// complement, put through a three-round shift-add-xor 64-bit mix and cut to
// 56 bits. hashes leave packed from hash_0 upward with their count; unused
// fields are zero. tlast on the way in ends the sequence (its bases are used
// first, then the history is cleared) and comes back as tlast on the result.
// one request is taken every cycle unless the output stalls; each goes through:
// a front register that forms all lane windows at once, one canonical stage,
// four hash stages per lane and the merge/output register. the whole pipeline
// advances together, so while a result waits at the output the block stalls.
// there is no clearing pass after reset.
module canonical_kmer_hasher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // base_0 .. base_7 (8 bits each), base_count (4 bits), zero pad
  input  logic [ckh_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,   // end_of_sequence
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // hash_0 .. hash_7 (56 bits each), hash_count (4 bits), zero pad
  output logic [ckh_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast    // sequence_done
);

  // the pipeline moves whenever the output register is free or being drained
  logic               adv;
  ckh_pkg::win_t      win  [ckh_pkg::LANES];
  ckh_pkg::hash_t     hash [ckh_pkg::LANES];
  ckh_pkg::ckh_ctrl_t front_ctrl;
  ckh_pkg::ckh_ctrl_t ctrl_pipe [ckh_pkg::HASH_DEPTH];

  assign adv = !m_tvalid || m_tready;

  ckh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .win      (win),
    .ctrl     (front_ctrl)
  );

  // one hash lane per base position of the request
  for (genvar g = 0; g < ckh_pkg::LANES; g++) begin : g_lane
    ckh_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .win  (win[g]),
      .hash (hash[g])
    );
  end

  // control rides alongside the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < ckh_pkg::HASH_DEPTH; s++) begin
        ctrl_pipe[s] <= '0;
      end
    end else if (adv) begin
      ctrl_pipe[0] <= front_ctrl;
      for (int s = 1; s < ckh_pkg::HASH_DEPTH; s++) begin
        ctrl_pipe[s] <= ctrl_pipe[s-1];
      end
    end
  end

  ckh_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .ctrl     (ctrl_pipe[ckh_pkg::HASH_DEPTH-1]),
    .hashes   (hash),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/sv/canonical_kmer_hasher_test.sv =====
// self-checking testbench for the canonical k-mer hasher stream block
module canonical_kmer_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 16;     // pipeline is seven deep, leave some margin
  localparam logic [ckh_pkg::BASE_W-1:0] ASCII_A = 8'h41;
  localparam logic [ckh_pkg::BASE_W-1:0] ASCII_N = 8'h4e;

  // one request as driven: bases plus count on tdata, end of sequence on tlast
  typedef struct packed {
    logic                                          eos;
    logic [ckh_pkg::COUNT_W-1:0]                   count;
    logic [ckh_pkg::LANES-1:0][ckh_pkg::BASE_W-1:0] bases;
  } base_group_t;

  // one result as expected back: hashes plus count on tdata, sequence end on tlast
  typedef struct packed {
    logic                                          done;
    logic [ckh_pkg::COUNT_W-1:0]                   count;
    logic [ckh_pkg::LANES-1:0][ckh_pkg::HASH_W-1:0] hashes;
  } hash_group_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ckh_pkg::IN_DATA_W-1:0]   s_tdata = '0;
  logic                            s_tlast = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ckh_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic                            m_tlast;

  // predictor state: the last 27 base codes (newest low) and how many are held
  logic [ckh_pkg::HIST_W-1:0]      base_history = '0;
  logic [ckh_pkg::SEEN_W-1:0]      held_bases = '0;

  hash_group_t            pending_hashes[$];
  hash_group_t            oldest_hashes;
  int                     mismatch_count = 0;
  int                     cycle_count = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;

  canonical_kmer_hasher u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // works out the hashes one request produces and moves the window history on
  function automatic hash_group_t hash_bases(base_group_t grp);
    hash_group_t                 res;
    int                          taken;
    int                          produced;
    logic [1:0]                  code;
    ckh_pkg::win_t               fwd;
    ckh_pkg::win_t               rc;
    ckh_pkg::win_t               canon;
    logic [ckh_pkg::MIX_W-1:0]   k;
    res = '0;
    produced = 0;
    taken = (grp.count > ckh_pkg::LANES) ? ckh_pkg::LANES : int'(grp.count);
    for (int i = 0; i < taken; i++) begin
      case (grp.bases[i])
        ckh_pkg::ASCII_C: code = ckh_pkg::CODE_C;
        ckh_pkg::ASCII_G: code = ckh_pkg::CODE_G;
        ckh_pkg::ASCII_T: code = ckh_pkg::CODE_T;
        default: code = ckh_pkg::CODE_A;   // any other byte counts as a
      endcase
      fwd = {base_history, code};
      if (held_bases >= ckh_pkg::SEEN_W'(ckh_pkg::KMER_LENGTH - 1)) begin
        // reverse complement: base order flipped, each code xor 3
        for (int b = 0; b < ckh_pkg::KMER_LENGTH; b++) begin
          rc[2*(ckh_pkg::KMER_LENGTH-1-b) +: 2] = fwd[2*b +: 2] ^ 2'b11;
        end
        canon = (fwd < rc) ? fwd : rc;
        // three-round shift-add-xor mix in full 64 bits, cut down at the end
        k = ckh_pkg::MIX_W'(canon);
        k = ~k + (k << 21);
        k = k ^ (k >> 24);
        k = k + (k << 3) + (k << 8);
        k = k ^ (k >> 14);
        k = k + (k << 2) + (k << 4);
        k = k ^ (k >> 28);
        k = k + (k << 31);
        res.hashes[produced] = k[ckh_pkg::HASH_W-1:0];
        produced++;
      end else begin
        held_bases = held_bases + 1'b1;
      end
      base_history = fwd[ckh_pkg::HIST_W-1:0];
    end
    res.count = ckh_pkg::COUNT_W'(produced);
    res.done  = grp.eos;
    if (grp.eos) begin
      base_history = '0;
      held_bases   = '0;
    end
    return res;
  endfunction

  // random group: nucleotide letters, with noise_pct of the bytes fully random
  function automatic base_group_t make_group(int count, bit eos, int noise_pct);
    base_group_t grp;
    grp.eos   = eos;
    grp.count = ckh_pkg::COUNT_W'(count);
    for (int i = 0; i < ckh_pkg::LANES; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        grp.bases[i] = ckh_pkg::BASE_W'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0: grp.bases[i] = ASCII_A;
          1: grp.bases[i] = ckh_pkg::ASCII_C;
          2: grp.bases[i] = ckh_pkg::ASCII_G;
          default: grp.bases[i] = ckh_pkg::ASCII_T;
        endcase
      end
    end
    return grp;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // sends one request, with random gaps ahead of it, and books its hashes
  task automatic send_group(base_group_t grp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ckh_pkg::IN_DATA_W'({grp.count, grp.bases});
    s_tlast  <= grp.eos;
    do @(posedge clk); while (!s_tready);
    pending_hashes.push_back(hash_bases(grp));
  endtask

  // result checker, against the oldest outstanding expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("result with none expected", 64'(m_tdata), '0);
      end else begin
        oldest_hashes = pending_hashes.pop_front();
        for (int i = 0; i < ckh_pkg::LANES; i++) begin
          if (m_tdata[i*ckh_pkg::HASH_W +: ckh_pkg::HASH_W] !== oldest_hashes.hashes[i])
            report_mismatch($sformatf("hash_%0d", i),
                            64'(m_tdata[i*ckh_pkg::HASH_W +: ckh_pkg::HASH_W]),
                            64'(oldest_hashes.hashes[i]));
        end
        if (m_tdata[ckh_pkg::LANES*ckh_pkg::HASH_W +: ckh_pkg::COUNT_W]
            !== oldest_hashes.count)
          report_mismatch("hash_count",
                          64'(m_tdata[ckh_pkg::LANES*ckh_pkg::HASH_W +: ckh_pkg::COUNT_W]),
                          64'(oldest_hashes.count));
        if (m_tlast !== oldest_hashes.done)
          report_mismatch("sequence_done", 64'(m_tlast), 64'(oldest_hashes.done));
      end
    end
  end

  // 28 identical bases, then a sequence long enough to fill every lane with a hash
  task automatic test_window_fill();
    base_group_t grp;
    grp = '0;
    grp.bases = {ckh_pkg::LANES{ASCII_A}};
    grp.count = 4'd8;
    repeat (3) send_group(grp);
    grp.count = 4'd4;
    grp.eos   = 1'b1;           // only the 28th base completes a window
    send_group(grp);
    grp.bases = {ckh_pkg::LANES{ckh_pkg::ASCII_T}};
    grp.count = 4'd8;
    grp.eos   = 1'b0;
    repeat (4) send_group(grp);
    for (int i = 0; i < 3; i++) send_group(make_group(8, i == 2, 0));
  endtask

  // 27 bases then end of sequence: nothing may be hashed
  task automatic test_short_sequence();
    send_group(make_group(8, 1'b0, 0));
    send_group(make_group(8, 1'b0, 0));
    send_group(make_group(8, 1'b0, 0));
    send_group(make_group(3, 1'b1, 0));
  endtask

  // empty groups and counts past the lane count
  task automatic test_count_extremes();
    send_group(make_group(0, 1'b0, 0));
    send_group(make_group(0, 1'b1, 0));     // empty group that ends a sequence
    for (int i = 0; i < 3; i++) send_group(make_group(9, 1'b0, 0));
    send_group(make_group(15, 1'b0, 100));
    send_group(make_group(0, 1'b1, 0));
  endtask

  // bytes outside the four letters are taken as a
  task automatic test_byte_coding();
    base_group_t grp;
    grp = '0;
    grp.count = 4'd8;
    grp.bases = {8'h00, 8'hff, 8'h63, 8'h67, 8'h74, 8'h80, ASCII_N, 8'h61};
    repeat (4) send_group(grp);
    grp.bases = {ckh_pkg::ASCII_T, ckh_pkg::ASCII_G, ckh_pkg::ASCII_C, ASCII_A,
                 8'h7f, 8'h55, 8'h42, 8'h01};
    grp.eos   = 1'b1;
    send_group(grp);
  endtask

  // mostly well-formed sequences of random length; some noise and odd counts
  task automatic test_random_streams(int items, int send_pct, int recv_pct);
    int kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < items; n++) begin
      kind = $urandom_range(99);
      if (kind < 85)
        send_group(make_group($urandom_range(ckh_pkg::LANES, 1),
                              $urandom_range(24) == 0, 4));
      else if (kind < 93)
        send_group(make_group($urandom_range(1) ? 0 :
                              $urandom_range(15, ckh_pkg::LANES + 1),
                              $urandom_range(3) == 0, 50));
      else
        send_group(make_group($urandom_range(15), $urandom_range(1), 100));
    end
  endtask

  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 46;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_window_fill();
    test_short_sequence();
    test_count_extremes();
    test_byte_coding();
    test_random_streams(650, 23, 46);
    test_random_streams(650, 46, 23);
    test_random_streams(650, 0, 0);

    s_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ckh_pkg.sv
rtl/core/ckh_front.sv
rtl/core/ckh_lane.sv
rtl/core/ckh_merge.sv
rtl/core/canonical_kmer_hasher.sv
tb/sv/canonical_kmer_hasher_test.sv
